// File: design/rhh_pkg.sv
// Shared types and constants for the HLS to RGB pixel converter.
package rhh_pkg;
    localparam int HDEG60  = 60 * 256;
    localparam int HDEG120 = 120 * 256;
    localparam int HDEG180 = 180 * 256;
    localparam int HDEG240 = 240 * 256;
    localparam int HDEG360 = 360 * 256;
    localparam int QUEUE_DEPTH = 4;

    // which hue byte is the largest
    typedef enum logic [1:0] {
        SEC_RED,
        SEC_GREEN,
        SEC_BLUE
    } t_sector;

    // part of the channel curve a hue falls on
    typedef enum logic [1:0] {
        SEG_RAMP,
        SEG_TOP,
        SEG_BOTTOM
    } t_seg;

    typedef struct packed {
        logic [7:0] hue_red;
        logic [7:0] hue_green;
        logic [7:0] hue_blue;
        logic [7:0] lightness;
        logic [7:0] saturation;
    } t_pix_in;

    typedef struct packed {
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
    } t_pix_out;

    // classified request passed from front to back
    typedef struct packed {
        logic        white;
        logic        grey;
        logic [7:0]  lightness;
        logic [16:0] m1;
        logic [16:0] span;
        logic        neg;
        logic [14:0] mag;   // |num| * 60*256 needs 8+14 bits; kept as num magnitude
        logic [7:0]  den;
        t_sector     sector;
    } t_req;
endpackage

// File: design/rhh_stream_if.sv
// Valid/ready stream interface used for both pixel channels.
interface rhh_stream_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: design/rgb_hue_to_hls_rgb_pixel.sv
// Top level of the HLS to RGB pixel converter.
// Usage:
//   s_in  : sink channel, one request carries hue_red/green/blue, lightness,
//           saturation bytes; accepted when valid and ready are high.
//   m_out : source channel, one request of out_red/green/blue per input.
// Throughput: one pixel per cycle, sustained while the output is not held.
// Pipeline: 1 front register, the request queue, 16 divider stages
//   (one quotient bit each for the hue angle), then 3 stages for channel
//   lookup, ramp multiply and byte scaling.
// Reset: synchronous, active low; clears all valid flags and the queue,
//   nothing else needs clearing.
// Stall: the back pipeline freezes while the output is held; the queue
//   then absorbs up to QDEPTH requests before the front stops accepting.
module rgb_hue_to_hls_rgb_pixel #(
    parameter int QDEPTH = rhh_pkg::QUEUE_DEPTH
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    rhh_stream_if.sink   s_in,
    rhh_stream_if.source m_out
);
    import rhh_pkg::*;
    logic fv, fr, qv, qr;
    t_req freq, qreq;

    rhh_front u_front (.i_clk, .i_rst_n, .s_in, .o_valid(fv), .o_req(freq), .i_ready(fr));
    rhh_queue #(.DEPTH(QDEPTH)) u_queue (.i_clk, .i_rst_n, .i_valid(fv), .i_req(freq),
        .o_ready(fr), .o_valid(qv), .o_req(qreq), .i_ready(qr));
    rhh_back u_back (.i_clk, .i_rst_n, .i_valid(qv), .i_req(qreq), .o_ready(qr), .m_out);

`ifndef SYNTHESIS
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_out.valid && !m_out.ready |=> m_out.valid && $stable(m_out.data))
        else $error("output dropped while stalled");
    a_qflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fv && !fr |=> fv)
        else $error("front request lost at full queue");
`endif
endmodule

// File: design/rhh_front.sv
// Front end: hue sector, divide operands and m1/m2 levels.
module rhh_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    rhh_stream_if.sink     s_in,
    output logic           o_valid,
    output rhh_pkg::t_req  o_req,
    input  logic           i_ready
);
    import rhh_pkg::*;
    logic [7:0] r, g, b, mx, mn, l, s;
    logic [8:0] num;
    logic       neg;
    t_sector    sec;
    logic [16:0] m2, m1;
    logic [15:0] ls;
    logic        r_valid;
    t_req        r_req, n_req;

    always_comb begin
        r = s_in.data.hue_red; g = s_in.data.hue_green; b = s_in.data.hue_blue;
        l = s_in.data.lightness; s = s_in.data.saturation;
        mx = (r > g) ? ((r > b) ? r : b) : ((g > b) ? g : b);
        mn = (r < g) ? ((r < b) ? r : b) : ((g < b) ? g : b);
        if (r == mx) begin
            sec = SEC_RED; num = {1'b0, g} - {1'b0, b};
        end else if (g == mx) begin
            sec = SEC_GREEN; num = {1'b0, b} - {1'b0, r};
        end else begin
            sec = SEC_BLUE; num = {1'b0, r} - {1'b0, g};
        end
        neg = num[8];
        ls = l * s;
        if (l <= 8'd128) m2 = 17'(l) * 17'(9'd256 + {1'b0, s});
        else m2 = 17'({l, 8'd0} + {s, 8'd0} - {1'b0, ls});
        m1 = 17'({l, 9'd0} - {1'b0, m2});
        n_req.white     = (mx == mn);
        n_req.grey      = (s == 8'd0);
        n_req.lightness = l;
        n_req.m1        = m1;
        n_req.span      = m2 - m1;
        n_req.neg       = neg;
        n_req.mag       = 15'(neg ? 9'(-num) : num);
        n_req.den       = mx - mn;
        n_req.sector    = sec;
    end

    assign s_in.ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_req = r_req;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_valid <= 1'b0;
        else if (s_in.ready) r_valid <= s_in.valid;
        if (s_in.valid && s_in.ready) r_req <= n_req;
    end
endmodule

// File: design/rhh_queue.sv
// Short request queue between front and back ends.
module rhh_queue #(parameter int DEPTH = rhh_pkg::QUEUE_DEPTH) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  rhh_pkg::t_req i_req,
    output logic          o_ready,
    output logic          o_valid,
    output rhh_pkg::t_req o_req,
    input  logic          i_ready
);
    import rhh_pkg::*;
    localparam int AW = $clog2(DEPTH);
    t_req r_mem [DEPTH];
    logic [AW-1:0] r_wp, r_rp;
    logic [AW:0]   r_cnt;
    logic wr, rd;
    assign o_ready = r_cnt != (AW+1)'(DEPTH);
    assign o_valid = r_cnt != '0;
    assign o_req = r_mem[r_rp];
    assign wr = i_valid && o_ready;
    assign rd = o_valid && i_ready;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0;
        end else begin
            if (wr) r_wp <= (r_wp == AW'(DEPTH-1)) ? '0 : r_wp + 1'b1;
            if (rd) r_rp <= (r_rp == AW'(DEPTH-1)) ? '0 : r_rp + 1'b1;
            r_cnt <= r_cnt + (AW+1)'(wr) - (AW+1)'(rd);
        end
        if (wr) r_mem[r_wp] <= i_req;
    end
endmodule

// File: design/rhh_back.sv
// Back end: pipelined hue divide, channel lookup and ramp scaling.
module rhh_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  rhh_pkg::t_req  i_req,
    output logic           o_ready,
    rhh_stream_if.source   m_out
);
    import rhh_pkg::*;
    localparam int NS = 16;     // quotient bits of |num|*15360/den
    localparam int RW = 24;

    // stage pipe: restoring division, one quotient bit per stage
    logic          r_v   [NS+1];
    t_req          r_q   [NS+1];
    logic [RW-1:0] r_rem [NS+1];
    logic [NS-1:0] r_quo [NS+1];
    logic [RW-1:0] dividend;
    logic          adv;

    // output stages
    logic          r_v2, r_v3, r_ov;
    t_req          r_q2, r_q3;
    logic [16:0]   r_h;
    logic [16:0]   r_t [3];
    t_seg          r_k [3];
    logic [33:0]   r_p [3];
    t_pix_out      r_o;

    assign adv = !r_ov || m_out.ready;
    assign o_ready = adv;
    assign dividend = RW'(i_req.mag) * RW'(HDEG60);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i <= NS; i++) r_v[i] <= 1'b0;
            r_v2 <= 1'b0; r_v3 <= 1'b0; r_ov <= 1'b0;
        end else if (adv) begin
            r_v[0] <= i_valid;
            for (int i = 1; i <= NS; i++) r_v[i] <= r_v[i-1];
            r_v2 <= r_v[NS]; r_v3 <= r_v2; r_ov <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_q[0] <= i_req; r_rem[0] <= dividend; r_quo[0] <= '0;
            for (int i = 1; i <= NS; i++) begin
                logic [RW-1:0] dv;
                dv = RW'(r_q[i-1].den) << (NS - i);
                r_q[i] <= r_q[i-1];
                if (r_q[i-1].den != 8'd0 && r_rem[i-1] >= dv) begin
                    r_rem[i] <= r_rem[i-1] - dv;
                    r_quo[i] <= r_quo[i-1] | (NS'(1) << (NS - i));
                end else begin
                    r_rem[i] <= r_rem[i-1];
                    r_quo[i] <= r_quo[i-1];
                end
            end
        end
    end

    // hue, wrap and per-channel segment
    function automatic logic [16:0] wrapf(input logic signed [18:0] x);
        logic signed [18:0] y;
        y = x;
        if (y < 0) y = y + 19'sd92160;
        if (y > 19'sd92160) y = y - 19'sd92160;
        return 17'(y);
    endfunction

    always_comb begin
        logic signed [18:0] hb, hq;
        hq = r_q[NS].neg ? -$signed({3'b0, r_quo[NS]}) : $signed({3'b0, r_quo[NS]});
        case (r_q[NS].sector)
            SEC_RED:   hb = 19'sd0;
            SEC_GREEN: hb = 19'(HDEG120);
            default:   hb = 19'(HDEG240);
        endcase
        r_h = wrapf(hb + hq);
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            logic signed [18:0] hs;
            logic [16:0] hc;
            r_q2 <= r_q[NS];
            for (int c = 0; c < 3; c++) begin
                hs = $signed({2'b0, r_h});
                hc = (c == 0) ? wrapf(hs + 19'(HDEG120)) :
                     (c == 1) ? r_h : wrapf(hs - 19'(HDEG120));
                if (hc < 17'(HDEG60)) begin
                    r_k[c] <= SEG_RAMP; r_t[c] <= hc;
                end else if (hc < 17'(HDEG180)) begin
                    r_k[c] <= SEG_TOP; r_t[c] <= '0;
                end else if (hc < 17'(HDEG240)) begin
                    r_k[c] <= SEG_RAMP; r_t[c] <= 17'(HDEG240) - hc;
                end else begin
                    r_k[c] <= SEG_BOTTOM; r_t[c] <= '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_q3 <= r_q2;
            for (int c = 0; c < 3; c++) begin
                case (r_k[c])
                    SEG_RAMP: r_p[c] <= r_q2.span * r_t[c];
                    SEG_TOP:  r_p[c] <= 34'(r_q2.span) * 34'(HDEG60);
                    default:  r_p[c] <= '0;
                endcase
            end
        end
    end

    // span*t/15360 = ((span*t)>>10)/15 ; exact via reciprocal on bounded value
    function automatic logic [7:0] tobyte(input logic [16:0] m1, input logic [33:0] p);
        logic [23:0] a;
        logic [47:0] e;
        logic [23:0] q;
        logic [17:0] v;
        a = 24'(p >> 10);
        e = a * 48'd1118482;           // ceil(2^24/15)
        q = 24'(e >> 24);
        if (q * 24'd15 > a) q = q - 1'b1;
        v = {1'b0, m1} + 18'(q);
        return (v[17:8] > 10'd255) ? 8'hff : v[15:8];
    endfunction

    always_ff @(posedge i_clk) begin
        if (adv) begin
            if (r_q3.white) r_o <= '{8'hff, 8'hff, 8'hff};
            else if (r_q3.grey) r_o <= '{r_q3.lightness, r_q3.lightness, r_q3.lightness};
            else begin
                r_o.out_red   <= tobyte(r_q3.m1, r_p[0]);
                r_o.out_green <= tobyte(r_q3.m1, r_p[1]);
                r_o.out_blue  <= tobyte(r_q3.m1, r_p[2]);
            end
        end
    end

    assign m_out.valid = r_ov;
    assign m_out.data  = r_o;
endmodule
